>>> hdl/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BPFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`else

`define BPFA_ASSERT(lbl, clk, rst_n, prop)

`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

>>> hdl/bpfa_pkg.sv
// types, constants and helpers of the bitmap page frame allocator
// no dependencies
package bpfa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int WORD_W     = 64;
  localparam int MAP_WORDS  = NUM_PAGES / WORD_W;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_W);
  localparam int PAGE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int LIM_WORD_W = CNT_W - BIT_AW;
  localparam int FIFO_DEPTH = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(4096);
  localparam logic [CNT_W-1:0] PAGES_CNT = CNT_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MANAGED_PAGES = 1'b0,
    CFG_INITIAL_FREE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_RESERVE,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic              granted;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
  } out_item_t;

  typedef struct packed {
    cmd_e               kind;
    logic               in_range;
    logic [WORD_AW-1:0] word;
    logic [BIT_AW-1:0]  bit_sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } bpfa_status_t;

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - CNT_W'(1) : v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < COUNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

endpackage

>>> hdl/bpfa_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bpfa_fifo.sv
// short command queue between the front and back parts
// depends on bpfa_pkg
module bpfa_fifo
  import bpfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (count_q == CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

>>> hdl/bpfa_front.sv
// input side: takes request transfers and decodes them into commands
// depends on bpfa_pkg
module bpfa_front
  import bpfa_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     fifo_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  op_e op;

  assign op         = op_e'(in_data_i.op);
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    cmd_o.in_range = (CNT_W'(in_data_i.page) < PAGES_CNT);
    cmd_o.word     = in_data_i.page[BIT_AW +: WORD_AW];
    cmd_o.bit_sel  = in_data_i.page[BIT_AW-1:0];
    case (op)
      OP_ALLOC:   cmd_o.kind = CMD_ALLOC;
      OP_FREE:    cmd_o.kind = CMD_FREE;
      OP_RESERVE: cmd_o.kind = CMD_RESERVE;
      default:    cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

>>> hdl/bpfa_back.sv
// execution side: page map, counters, first fit scan and result register
// depends on bpfa_pkg and bpfa_ram
module bpfa_back
  import bpfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  fifo_empty_i,
  input  cmd_t                  cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  output bpfa_status_t          status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_DONE
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [WORD_AW-1:0]     word_q;
  logic [MAP_WORDS-1:0]   row_vld_q;
  logic [CNT_W-1:0]       managed_q;
  logic [CNT_W-1:0]       free_q;
  logic [CNT_W-1:0]       used_q;
  logic [PAGE_W-1:0]      pend_page_q;
  logic                   pend_grant_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  logic                   ram_we;
  logic [WORD_AW-1:0]     ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [WORD_AW-1:0]     ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]       limit;
  logic [LIM_WORD_W-1:0]  limit_word;
  logic [LIM_WORD_W-1:0]  scan_word;
  logic [WORD_W-1:0]      scan_row;
  logic [WORD_W-1:0]      mod_row;
  logic [WORD_W-1:0]      scan_mask;
  logic [WORD_W-1:0]      avail;
  logic                   found;
  logic [BIT_AW-1:0]      found_bit;
  logic                   scan_end;
  logic                   out_free;

  function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_AW'(i);
    end
    return idx;
  endfunction

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign limit      = (managed_q > PAGES_CNT) ? PAGES_CNT : managed_q;
  assign limit_word = limit[CNT_W-1:BIT_AW];
  assign scan_word  = LIM_WORD_W'(word_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_o      = (state_q == S_IDLE) && !fifo_empty_i;

  // rows never written since reset read as all free
  assign scan_row = row_vld_q[word_q] ? ram_rdata : '0;
  assign mod_row  = row_vld_q[cmd_q.word] ? ram_rdata : '0;

  always_comb begin
    if (scan_word < limit_word) begin
      scan_mask = '1;
    end else if (scan_word == limit_word) begin
      scan_mask = (WORD_W'(1) << limit[BIT_AW-1:0]) - WORD_W'(1);
    end else begin
      scan_mask = '0;
    end
  end

  assign avail     = ~scan_row & scan_mask;
  assign found     = (avail != '0);
  assign found_bit = lowest_set(avail);
  assign scan_end  = ({scan_word + LIM_WORD_W'(1), BIT_AW'(0)} >= limit);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = word_q + WORD_AW'(1);
    ram_we    = 1'b0;
    ram_waddr = cmd_q.word;
    ram_wdata = mod_row;
    case (state_q)
      S_IDLE: begin
        ram_re    = pop_o;
        ram_raddr = (cmd_i.kind == CMD_ALLOC) ? '0 : cmd_i.word;
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_we    = found;
        ram_waddr = word_q;
        ram_wdata = scan_row | (WORD_W'(1) << found_bit);
      end
      S_MODIFY: begin
        ram_we = 1'b1;
        if (cmd_q.kind == CMD_RESERVE) begin
          ram_wdata = mod_row | (WORD_W'(1) << cmd_q.bit_sel);
        end else begin
          ram_wdata = mod_row & ~(WORD_W'(1) << cmd_q.bit_sel);
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      word_q       <= '0;
      row_vld_q    <= '0;
      managed_q    <= CNT_W'(4096);
      free_q       <= COUNT_MAX;
      used_q       <= '0;
      pend_page_q  <= '0;
      pend_grant_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MANAGED_PAGES: managed_q <= CNT_W'(cfg_data_i);
          CFG_INITIAL_FREE: begin
            free_q <= (CNT_W'(cfg_data_i) > COUNT_MAX) ? COUNT_MAX : CNT_W'(cfg_data_i);
          end
          default: managed_q <= managed_q;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q        <= cmd_i;
            word_q       <= '0;
            pend_page_q  <= '0;
            pend_grant_q <= 1'b0;
            case (cmd_i.kind)
              CMD_ALLOC: begin
                state_q <= (free_q == '0 || limit == '0) ? S_DONE : S_SCAN;
              end
              CMD_FREE: begin
                free_q  <= sat_inc(free_q);
                used_q  <= sat_dec(used_q);
                state_q <= cmd_i.in_range ? S_MODIFY : S_DONE;
              end
              CMD_RESERVE: begin
                free_q  <= sat_dec(free_q);
                used_q  <= sat_inc(used_q);
                state_q <= cmd_i.in_range ? S_MODIFY : S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            row_vld_q[word_q] <= 1'b1;
            free_q            <= sat_dec(free_q);
            used_q            <= sat_inc(used_q);
            pend_page_q       <= PAGE_W'({word_q, found_bit});
            pend_grant_q      <= 1'b1;
            state_q           <= S_DONE;
          end else if (scan_end) begin
            state_q <= S_DONE;
          end else begin
            word_q <= word_q + WORD_AW'(1);
          end
        end
        S_MODIFY: begin
          row_vld_q[cmd_q.word] <= 1'b1;
          state_q               <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_data_q.page_index <= pend_page_q;
            out_data_q.granted    <= pend_grant_q;
            out_data_q.free_pages <= free_q;
            out_data_q.used_pages <= used_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.busy     = (state_q != S_IDLE);
  assign status_o.scanning = (state_q == S_SCAN);

endmodule

>>> hdl/bitmap_page_frame_allocator.sv
// top level of the bitmap page frame allocator
// depends on bpfa_pkg, bpfa_front, bpfa_fifo, bpfa_back and assert_macros.svh
//
// usage:
//   requests enter on the in channel (valid/ready); op 0 allocates the lowest
//   free page below managed_pages, op 1 frees and op 2 reserves a page.
//   every request gives exactly one result transfer on the out channel with
//   the granted page, the granted flag and both page counters.
//   the config port writes managed_pages (index 0) or loads the free counter
//   (index 1); write only while no request is in flight.
// timing:
//   free and reserve requests pass from the queue through the idle, modify and
//   done states, unknown ops and allocates refused up front go from idle to
//   done, and allocate reads one 64-page map row per cycle in the scan state.
//   done registers the result once the output register is free. a two entry
//   command queue takes new requests while one is executing.
// reset:
//   the map reads as all free through per-row valid bits, so the block is
//   ready the cycle after reset with no clearing pass.
// stalls:
//   a held result sits in the output register; the back end waits, then the
//   queue fills and in_ready_o drops.
`include "assert_macros.svh"

module bitmap_page_frame_allocator
  import bpfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  logic         fifo_push;
  logic         fifo_pop;
  logic         fifo_full;
  logic         fifo_empty;
  cmd_t         front_cmd;
  cmd_t         head_cmd;
  bpfa_status_t back_stat;

  bpfa_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .cmd_o       (front_cmd)
  );

  bpfa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .cmd_o   (head_cmd)
  );

  bpfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (head_cmd),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .status_o     (back_stat)
  );

  `BPFA_ASSERT(a_pop_when_idle, clk_i, rst_ni, fifo_pop |-> !back_stat.busy && !fifo_empty)
  `BPFA_ASSERT(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(back_stat.busy))
  `BPFA_ASSERT(a_scan_no_pop, clk_i, rst_ni, back_stat.scanning |-> !fifo_pop)
  `BPFA_ASSERT_NEVER(a_grant_counts, clk_i, rst_ni,
                     out_valid_o && out_data_o.granted && out_data_o.used_pages == '0)

endmodule

>>> tb/bitmap_page_frame_allocator_tb.sv
// self-checking testbench for the bitmap page frame allocator
// needs bpfa_pkg and the allocator rtl; drives a directed table, then random
// phases under several map sizes and free counter loads, checked by a predictor
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;
  localparam int NUM_PHASES  = 6;
  localparam int IDLE_PCT    = 11;

  typedef struct packed {
    logic      is_write;
    cfg_idx_e  reg_sel;
    logic [CFG_DATA_W-1:0] reg_value;
    op_e       op;
    logic [PAGE_W-1:0] page;
    logic      known;
    out_item_t known_res;
  } plan_row_t;

  localparam int PLAN_LEN = 29;
  localparam plan_row_t DIRECTED [PLAN_LEN] = '{
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b1, {12'd1 - 12'd1, 1'b1, 13'd4095, 13'd1}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b1, {12'd1, 1'b1, 13'd4094, 13'd2}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'd0,   1'b1, {12'd0, 1'b0, 13'd4095, 13'd1}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'hfff, 1'b1, {12'd0, 1'b1, 13'd4094, 13'd2}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_RESERVE, 12'hfff, 1'b1, {12'd0, 1'b0, 13'd4093, 13'd3}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_NONE,    12'hfff, 1'b1, {12'd0, 1'b0, 13'd4093, 13'd3}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'hfff, 1'b1, {12'd0, 1'b0, 13'd4094, 13'd2}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'hfff, 1'b1, {12'd0, 1'b0, 13'd4095, 13'd1}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'hfff, 1'b1, {12'd0, 1'b0, 13'd4096, 13'd0}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'd100, 1'b1, {12'd0, 1'b0, 13'd4096, 13'd0}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_RESERVE, 12'd1,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_RESERVE, 12'haaa, 1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_RESERVE, 12'h555, 1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'haaa, 1'b0, '0},
    '{1'b1, CFG_MANAGED_PAGES, 13'd0, OP_NONE,    12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b0, '0},
    '{1'b1, CFG_INITIAL_FREE,  13'd0, OP_NONE,    12'd0,   1'b0, '0},
    '{1'b1, CFG_MANAGED_PAGES, 13'd8191, OP_NONE, 12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b1, {12'd0, 1'b0, 13'd0, 13'd3}},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_RESERVE, 12'h800, 1'b0, '0},
    '{1'b1, CFG_INITIAL_FREE,  13'd8191, OP_NONE, 12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b0, '0},
    '{1'b1, CFG_MANAGED_PAGES, 13'd3, OP_NONE,    12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_FREE,    12'd1,   1'b0, '0},
    '{1'b0, CFG_MANAGED_PAGES, 13'd0, OP_ALLOC,   12'd0,   1'b0, '0},
    '{1'b1, CFG_MANAGED_PAGES, 13'd4096, OP_NONE, 12'd0,   1'b0, '0},
    '{1'b1, CFG_INITIAL_FREE,  13'd4096, OP_NONE, 12'd0,   1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  // predictor state
  logic [NUM_PAGES-1:0] frame_used;
  logic [CNT_W-1:0]     free_cnt;
  logic [CNT_W-1:0]     used_cnt;
  logic [CNT_W-1:0]     scan_limit;

  out_item_t awaited_replies[$];
  out_item_t oldest_reply;
  int        granted_pages[$];
  bit        calm;
  int        cycle_cnt = 0;
  int        n_items, n_granted, n_denied, n_frees, n_reserves, n_writes;
  int        n_replies, n_errors;

  bitmap_page_frame_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bitmap_page_frame_allocator_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch on reply %0d: %s", n_replies, msg);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_replies++;
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with nothing outstanding");
      end else begin
        oldest_reply = awaited_replies.pop_front();
        if (out_data_o.page_index !== oldest_reply.page_index)
          report_mismatch($sformatf("page_index %0d, want %0d",
                                    out_data_o.page_index, oldest_reply.page_index));
        if (out_data_o.granted !== oldest_reply.granted)
          report_mismatch($sformatf("granted %0b, want %0b",
                                    out_data_o.granted, oldest_reply.granted));
        if (out_data_o.free_pages !== oldest_reply.free_pages)
          report_mismatch($sformatf("free_pages %0d, want %0d",
                                    out_data_o.free_pages, oldest_reply.free_pages));
        if (out_data_o.used_pages !== oldest_reply.used_pages)
          report_mismatch($sformatf("used_pages %0d, want %0d",
                                    out_data_o.used_pages, oldest_reply.used_pages));
      end
    end
  end

  function automatic out_item_t apply_page_op(input in_item_t req);
    out_item_t res;
    int        top;
    res = '0;
    case (op_e'(req.op))
      OP_ALLOC: begin
        if (free_cnt != 0) begin
          top = (scan_limit > NUM_PAGES) ? NUM_PAGES : int'(scan_limit);
          for (int i = 0; i < top; i++) begin
            if (!frame_used[i]) begin
              frame_used[i] = 1'b1;
              if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
              if (used_cnt < COUNT_MAX) used_cnt = used_cnt + 1'b1;
              res.page_index = PAGE_W'(i);
              res.granted    = 1'b1;
              break;
            end
          end
        end
      end
      OP_FREE: begin
        frame_used[req.page] = 1'b0;
        if (used_cnt != 0) used_cnt = used_cnt - 1'b1;
        if (free_cnt < COUNT_MAX) free_cnt = free_cnt + 1'b1;
      end
      OP_RESERVE: begin
        frame_used[req.page] = 1'b1;
        if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        if (used_cnt < COUNT_MAX) used_cnt = used_cnt + 1'b1;
      end
      default: ;
    endcase
    res.free_pages = free_cnt;
    res.used_pages = used_cnt;
    return res;
  endfunction

  // one request transfer; valid is left high for the caller to decide
  task automatic send_request(input in_item_t req, input logic known,
                              input out_item_t known_res);
    out_item_t res;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    res = apply_page_op(req);
    awaited_replies.push_back(known ? known_res : res);
    n_items++;
    case (op_e'(req.op))
      OP_ALLOC: begin
        if (res.granted) begin
          n_granted++;
          granted_pages.push_back(res.page_index);
        end else begin
          n_denied++;
        end
      end
      OP_FREE:    n_frees++;
      OP_RESERVE: n_reserves++;
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e sel, input logic [CFG_DATA_W-1:0] value);
    hold_until_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_MANAGED_PAGES) scan_limit = value;
    else free_cnt = (value > COUNT_MAX) ? COUNT_MAX : value;
    n_writes++;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(0, 1)) return PAGE_W'($urandom_range(0, 63));
    return PAGE_W'($urandom());
  endfunction

  initial begin
    in_item_t              req;
    int                    roll;
    int                    k;
    logic [CFG_DATA_W-1:0] limit_val;
    logic [CFG_DATA_W-1:0] load_val;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    frame_used  = '0;
    free_cnt    = CNT_W'(4096);
    used_cnt    = '0;
    scan_limit  = CNT_W'(4096);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (DIRECTED[r].is_write) begin
        write_reg(DIRECTED[r].reg_sel, DIRECTED[r].reg_value);
      end else begin
        req.op   = DIRECTED[r].op;
        req.page = DIRECTED[r].page;
        send_request(req, DIRECTED[r].known, DIRECTED[r].known_res);
        idle_gap();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin limit_val = 13'd4096; load_val = 13'd4096; end
        1: begin limit_val = 13'd24;   load_val = 13'd16;   end
        2: begin limit_val = 13'd8191; load_val = 13'd8191; end
        3: begin limit_val = 13'd1;    load_val = 13'd0;    end
        4: begin limit_val = 13'd64;   load_val = CFG_DATA_W'($urandom_range(0, 40)); end
        default: begin
          limit_val = CFG_DATA_W'($urandom_range(1, 4096));
          load_val  = CFG_DATA_W'($urandom_range(0, 4096));
        end
      endcase
      write_reg(CFG_MANAGED_PAGES, limit_val);
      write_reg(CFG_INITIAL_FREE, load_val);
      // one phase runs with both sides streaming at full rate
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) hold_until_drained();
        roll     = $urandom_range(0, 99);
        req.page = pick_page();
        if (roll < 40) begin
          req.op   = OP_ALLOC;
          req.page = PAGE_W'($urandom());
        end else if (roll < 65 && granted_pages.size() != 0) begin
          k        = $urandom_range(0, granted_pages.size() - 1);
          req.op   = OP_FREE;
          req.page = PAGE_W'(granted_pages[k]);
          granted_pages.delete(k);
        end else if (roll < 75) begin
          req.op = OP_FREE;
        end else if (roll < 94) begin
          req.op = OP_RESERVE;
        end else begin
          req.op = OP_NONE;
        end
        send_request(req, 1'b0, '0);
        idle_gap();
      end
      calm = 1'b0;
    end

    hold_until_drained();
    repeat (80) @(posedge clk_i);

    $display("covered %0d requests: %0d grants, %0d denied allocates, %0d frees, %0d reserves",
             n_items, n_granted, n_denied, n_frees, n_reserves);
    $display("%0d register writes, %0d replies checked, %0d mismatches",
             n_writes, n_replies, n_errors);
    if (n_errors == 0 && awaited_replies.size() == 0) begin
      $display("bitmap_page_frame_allocator_tb: clean");
    end else begin
      $display("bitmap_page_frame_allocator_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bpfa_pkg.sv
hdl/bpfa_ram.sv
hdl/bpfa_fifo.sv
hdl/bpfa_front.sv
hdl/bpfa_back.sv
hdl/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_tb.sv
